// File: rtl/core/reflector_cluster_extractor_defines.svh
// ----------------------------------------------------------------------------
// reflector cluster extractor assertion macros
// shared assertion forms, clocked on the rising edge, held off during reset
// ----------------------------------------------------------------------------
`ifndef REFLECTOR_CLUSTER_EXTRACTOR_DEFINES_SVH
`define REFLECTOR_CLUSTER_EXTRACTOR_DEFINES_SVH

// same-cycle implication
`define RCE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rce assertion failed");

// next-cycle implication
`define RCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rce assertion failed");

`endif

// File: rtl/core/rce_pkg.sv
// ----------------------------------------------------------------------------
// rce_pkg
// types and constants of the reflector cluster extractor
// ----------------------------------------------------------------------------
package rce_pkg;

    // scan geometry
    localparam int MAX_SCAN_POINTS = 4096;
    localparam int IDX_W           = $clog2(MAX_SCAN_POINTS);

    // field widths
    localparam int RANGE_W  = 16;
    localparam int INTEN_W  = 16;
    localparam int OFFS_W   = 20;
    localparam int STEP_W   = 12;
    localparam int SPAN_W   = 4;
    localparam int ANGLE_W  = 26;
    localparam int CNT_W    = 5;
    localparam int RSUM_W   = 20;
    localparam int ISUM_W   = 16;
    localparam int CFG_A_W  = 2;
    localparam int CFG_D_W  = 20;

    // largest group size
    localparam logic [CNT_W-1:0] MAX_POINTS = CNT_W'(16);

    // shared divider: one quotient bit per cycle over the product width
    localparam int QUO_W     = STEP_W + ISUM_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int DSTEP_W   = $clog2(DIV_STEPS);

    // angle limits
    localparam int TURN_W = ANGLE_W + 1;
    localparam logic [TURN_W-1:0] TURN_SAT = TURN_W'((64'd1 << ANGLE_W) - 64'd2);
    localparam int ASUM_W = ANGLE_W + 2;
    localparam logic signed [ASUM_W-1:0] ANGLE_CEIL  = ASUM_W'((64'sd1 <<< (ANGLE_W-1)) - 1);
    localparam logic signed [ASUM_W-1:0] ANGLE_FLOOR = -ASUM_W'(64'sd1 <<< (ANGLE_W-1));

    // register reset values
    localparam logic [INTEN_W-1:0]       RST_THRESHOLD = INTEN_W'(245);
    localparam logic signed [OFFS_W-1:0] RST_OFFSET    = -OFFS_W'(102944);
    localparam logic [STEP_W-1:0]        RST_STEP      = STEP_W'(286);
    localparam logic [SPAN_W-1:0]        RST_SPAN      = SPAN_W'(4);

    // register indexes
    typedef enum logic [CFG_A_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_OFFSET    = 2'd1,
        REG_STEP      = 2'd2,
        REG_SPAN      = 2'd3
    } t_reg_idx;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD,
        ST_DIV_R,
        ST_DIV_A,
        ST_SAT,
        ST_OUT,
        ST_END
    } t_state;

endpackage

// File: rtl/core/reflector_cluster_extractor.sv
// A sample that closes no group passes through the accept, check and end steps.
// Each reported group adds two runs of the shared radix-2 divider (mean range,
// then mean angle), plus load, saturate and output steps.
// One sample at a time: ready is low from accept until all its groups are taken.
// Reset (synchronous, active low) restores the register defaults and clears the
// sample index and the open group.
// ----------------------------------------------------------------------------
// reflector_cluster_extractor
// groups high-intensity lidar hits into clusters and reports mean range/angle
// ----------------------------------------------------------------------------
`include "reflector_cluster_extractor_defines.svh"

module reflector_cluster_extractor (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration writes
    input  logic                                 i_cfg_we,
    input  logic [rce_pkg::CFG_A_W-1:0]          i_cfg_addr,
    input  logic [rce_pkg::CFG_D_W-1:0]          i_cfg_data,
    // sample channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [rce_pkg::RANGE_W-1:0]          i_range_mm,
    input  logic [rce_pkg::INTEN_W-1:0]          i_intensity,
    input  logic                                 i_scan_end,
    // cluster channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [rce_pkg::RANGE_W-1:0]          o_cluster_range,
    output logic signed [rce_pkg::ANGLE_W-1:0]   o_cluster_angle,
    output logic [rce_pkg::CNT_W-1:0]            o_cluster_points,
    output logic                                 o_scan_last,
    output logic                                 o_run_last
);

    // configuration registers
    logic [rce_pkg::INTEN_W-1:0]        r_threshold;
    logic signed [rce_pkg::OFFS_W-1:0]  r_offset;
    logic [rce_pkg::STEP_W-1:0]         r_step_ang;
    logic [rce_pkg::SPAN_W-1:0]         r_span;

    // scan and group state
    rce_pkg::t_state                    r_state, n_state;
    logic [rce_pkg::IDX_W-1:0]          r_sample_index;
    logic                               r_group_open;
    logic [rce_pkg::IDX_W-1:0]          r_first_index;
    logic [rce_pkg::RSUM_W-1:0]         r_range_sum;
    logic [rce_pkg::ISUM_W-1:0]         r_index_sum;
    logic [rce_pkg::CNT_W-1:0]          r_point_count;

    // latched item
    logic [rce_pkg::RANGE_W-1:0]        r_rng;
    logic                               r_kept;
    logic                               r_end;

    // emission control
    logic                               r_phase;
    logic                               r_slast;
    logic                               r_rlast;

    // shared divider
    logic [rce_pkg::QUO_W-1:0]          r_prod;
    logic [rce_pkg::QUO_W-1:0]          r_quo;
    logic [rce_pkg::CNT_W-1:0]          r_rem;
    logic [rce_pkg::DSTEP_W-1:0]        r_dstep;
    logic [rce_pkg::RANGE_W-1:0]        r_mean_range;

    // output register
    logic                               r_out_valid;
    logic [rce_pkg::RANGE_W-1:0]        r_out_range;
    logic signed [rce_pkg::ANGLE_W-1:0] r_out_angle;
    logic [rce_pkg::CNT_W-1:0]          r_out_points;
    logic                               r_out_slast;
    logic                               r_out_rlast;

    logic                               in_acc;
    logic [rce_pkg::IDX_W-1:0]          idx_dist;
    logic                               join_grp;
    logic                               close_grp;
    logic                               div_last;
    logic [rce_pkg::CNT_W-1:0]          div_trial;
    logic                               div_ge;
    logic [rce_pkg::CNT_W-1:0]          div_rem_n;
    logic [rce_pkg::QUO_W-1:0]          div_quo_n;
    logic [rce_pkg::IDX_W:0]            idx_inc;
    logic [rce_pkg::IDX_W-1:0]          idx_next;
    logic [rce_pkg::TURN_W-1:0]         turn_sat;
    logic signed [rce_pkg::ASUM_W-1:0]  ang_sum;
    logic signed [rce_pkg::ASUM_W-1:0]  ang_clamp;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == rce_pkg::ST_IDLE);

    // group membership of the latched sample
    assign idx_dist  = r_sample_index - r_first_index;
    assign join_grp  = r_group_open && (r_sample_index >= r_first_index)
                       && (idx_dist <= rce_pkg::IDX_W'(r_span))
                       && (r_point_count < rce_pkg::MAX_POINTS);
    assign close_grp = r_kept && r_group_open && !join_grp;

    // radix-2 restoring divide step, divisor is the group size
    assign div_last  = (r_dstep == rce_pkg::DSTEP_W'(rce_pkg::DIV_STEPS - 1));
    assign div_trial = {r_rem[rce_pkg::CNT_W-2:0], r_quo[rce_pkg::QUO_W-1]};
    assign div_ge    = (div_trial >= r_point_count);
    assign div_rem_n = div_ge ? (div_trial - r_point_count) : div_trial;
    assign div_quo_n = {r_quo[rce_pkg::QUO_W-2:0], div_ge};

    // index advance with wrap
    assign idx_inc  = {1'b0, r_sample_index} + (rce_pkg::IDX_W+1)'(1);
    assign idx_next = (idx_inc >= (rce_pkg::IDX_W+1)'(rce_pkg::MAX_SCAN_POINTS))
                      ? '0 : idx_inc[rce_pkg::IDX_W-1:0];

    // angle: saturate the mean turn, add offset, clamp to output range
    assign turn_sat  = (r_quo > rce_pkg::QUO_W'(rce_pkg::TURN_SAT))
                       ? rce_pkg::TURN_SAT : r_quo[rce_pkg::TURN_W-1:0];
    assign ang_sum   = rce_pkg::ASUM_W'(r_offset) + $signed({1'b0, turn_sat});
    assign ang_clamp = (ang_sum > rce_pkg::ANGLE_CEIL) ? rce_pkg::ANGLE_CEIL
                     : (ang_sum < rce_pkg::ANGLE_FLOOR) ? rce_pkg::ANGLE_FLOOR : ang_sum;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rce_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rce_pkg::ST_IDLE:  if (in_acc) n_state = rce_pkg::ST_CHECK;
            rce_pkg::ST_CHECK: n_state = close_grp ? rce_pkg::ST_LOAD : rce_pkg::ST_END;
            rce_pkg::ST_LOAD:  n_state = rce_pkg::ST_DIV_R;
            rce_pkg::ST_DIV_R: if (div_last) n_state = rce_pkg::ST_DIV_A;
            rce_pkg::ST_DIV_A: if (div_last) n_state = rce_pkg::ST_SAT;
            rce_pkg::ST_SAT:   n_state = rce_pkg::ST_OUT;
            rce_pkg::ST_OUT: begin
                if (i_out_ready) n_state = r_phase ? rce_pkg::ST_IDLE : rce_pkg::ST_END;
            end
            rce_pkg::ST_END: begin
                n_state = (r_end && r_group_open) ? rce_pkg::ST_LOAD : rce_pkg::ST_IDLE;
            end
            default: n_state = rce_pkg::ST_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= rce_pkg::RST_THRESHOLD;
            r_offset    <= rce_pkg::RST_OFFSET;
            r_step_ang  <= rce_pkg::RST_STEP;
            r_span      <= rce_pkg::RST_SPAN;
        end else if (i_cfg_we) begin
            case (rce_pkg::t_reg_idx'(i_cfg_addr))
                rce_pkg::REG_THRESHOLD: r_threshold <= i_cfg_data[rce_pkg::INTEN_W-1:0];
                rce_pkg::REG_OFFSET:    r_offset    <= $signed(i_cfg_data[rce_pkg::OFFS_W-1:0]);
                rce_pkg::REG_STEP:      r_step_ang  <= i_cfg_data[rce_pkg::STEP_W-1:0];
                rce_pkg::REG_SPAN:      r_span      <= i_cfg_data[rce_pkg::SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // group state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_index <= '0;
            r_group_open   <= 1'b0;
            r_first_index  <= '0;
            r_range_sum    <= '0;
            r_index_sum    <= '0;
            r_point_count  <= '0;
            r_out_valid    <= 1'b0;
            r_phase        <= 1'b0;
        end else begin
            case (r_state)
                rce_pkg::ST_CHECK: begin
                    r_phase <= 1'b0;
                    if (r_kept && join_grp) begin
                        r_range_sum   <= r_range_sum + rce_pkg::RSUM_W'(r_rng);
                        r_index_sum   <= r_index_sum + rce_pkg::ISUM_W'(r_sample_index);
                        r_point_count <= r_point_count + rce_pkg::CNT_W'(1);
                    end else if (r_kept && !r_group_open) begin
                        r_group_open  <= 1'b1;
                        r_first_index <= r_sample_index;
                        r_range_sum   <= rce_pkg::RSUM_W'(r_rng);
                        r_index_sum   <= rce_pkg::ISUM_W'(r_sample_index);
                        r_point_count <= rce_pkg::CNT_W'(1);
                    end
                end
                rce_pkg::ST_SAT: r_out_valid <= 1'b1;
                rce_pkg::ST_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (!r_phase) begin
                            // the closing sample opens its own group
                            r_group_open  <= 1'b1;
                            r_first_index <= r_sample_index;
                            r_range_sum   <= rce_pkg::RSUM_W'(r_rng);
                            r_index_sum   <= rce_pkg::ISUM_W'(r_sample_index);
                            r_point_count <= rce_pkg::CNT_W'(1);
                        end else begin
                            // flushed at scan end
                            r_group_open   <= 1'b0;
                            r_first_index  <= '0;
                            r_range_sum    <= '0;
                            r_index_sum    <= '0;
                            r_point_count  <= '0;
                            r_sample_index <= '0;
                        end
                    end
                end
                rce_pkg::ST_END: begin
                    if (r_end && r_group_open) begin
                        r_phase <= 1'b1;
                    end else if (r_end) begin
                        r_group_open   <= 1'b0;
                        r_first_index  <= '0;
                        r_range_sum    <= '0;
                        r_index_sum    <= '0;
                        r_point_count  <= '0;
                        r_sample_index <= '0;
                    end else begin
                        r_sample_index <= idx_next;
                    end
                end
                default: ;
            endcase
        end
    end

    // item latch, divider and output payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            rce_pkg::ST_IDLE: begin
                r_rng  <= i_range_mm;
                r_kept <= (i_intensity >= r_threshold);
                r_end  <= i_scan_end;
            end
            rce_pkg::ST_CHECK: begin
                r_slast <= 1'b0;
                r_rlast <= !r_end;
            end
            rce_pkg::ST_END: begin
                r_slast <= 1'b1;
                r_rlast <= 1'b1;
            end
            rce_pkg::ST_LOAD: begin
                r_prod  <= rce_pkg::QUO_W'(r_step_ang) * rce_pkg::QUO_W'(r_index_sum);
                r_quo   <= rce_pkg::QUO_W'(r_range_sum);
                r_rem   <= '0;
                r_dstep <= '0;
            end
            rce_pkg::ST_DIV_R: begin
                if (div_last) begin
                    r_mean_range <= div_quo_n[rce_pkg::RANGE_W-1:0];
                    r_quo        <= r_prod;
                    r_rem        <= '0;
                    r_dstep      <= '0;
                end else begin
                    r_quo   <= div_quo_n;
                    r_rem   <= div_rem_n;
                    r_dstep <= r_dstep + rce_pkg::DSTEP_W'(1);
                end
            end
            rce_pkg::ST_DIV_A: begin
                r_quo   <= div_quo_n;
                r_rem   <= div_rem_n;
                r_dstep <= r_dstep + rce_pkg::DSTEP_W'(1);
            end
            rce_pkg::ST_SAT: begin
                r_out_range  <= r_mean_range;
                r_out_angle  <= ang_clamp[rce_pkg::ANGLE_W-1:0];
                r_out_points <= r_point_count;
                r_out_slast  <= r_slast;
                r_out_rlast  <= r_rlast;
            end
            default: ;
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_cluster_range  = r_out_range;
    assign o_cluster_angle  = r_out_angle;
    assign o_cluster_points = r_out_points;
    assign o_scan_last      = r_out_slast;
    assign o_run_last       = r_out_rlast;

    // checks
    `RCE_ASSERT_IMPL(a_idle_no_result, i_clk, i_rst_n, o_in_ready, !o_out_valid)
    `RCE_ASSERT_IMPL(a_open_count, i_clk, i_rst_n, r_group_open, (r_point_count != '0) && (r_point_count <= rce_pkg::MAX_POINTS))
    `RCE_ASSERT_IMPL(a_result_points, i_clk, i_rst_n, o_out_valid, o_cluster_points != '0)
    `RCE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule
